// ===== hdl/u16u8_pkg.sv =====
// Package for the UTF-16 to UTF-8 transcoder: types, constants and encode helpers.
package u16u8_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CP_W            = 21;

    typedef logic [CP_W-1:0] t_code_point;
    typedef logic [15:0]     t_code_unit;
    typedef logic [1:0]      t_byte_idx;

    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;  // 0xD800 >> 10
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;  // 0xDC00 >> 10
    localparam t_code_point PLANE_BASE    = 21'h10000;
    localparam t_code_point LIMIT_1B      = 21'h80;
    localparam t_code_point LIMIT_2B      = 21'h800;
    localparam t_code_point LIMIT_3B      = 21'h10000;
    localparam logic [7:0]  LEAD_2B       = 8'hC0;
    localparam logic [7:0]  LEAD_3B       = 8'hE0;
    localparam logic [7:0]  LEAD_4B       = 8'hF0;
    localparam logic [7:0]  CONT_TAG      = 8'h80;

    typedef enum logic [1:0] {
        UC_OTHER,
        UC_HIGH,
        UC_LOW
    } t_unit_class;

    localparam t_byte_idx LEN_1B = 2'd0;
    localparam t_byte_idx LEN_2B = 2'd1;
    localparam t_byte_idx LEN_3B = 2'd2;
    localparam t_byte_idx LEN_4B = 2'd3;

    function automatic t_unit_class classify(input t_code_unit unit);
        t_unit_class c;
        c = UC_OTHER;
        if (unit[15:10] == HIGH_SURR_TAG) c = UC_HIGH;
        else if (unit[15:10] == LOW_SURR_TAG) c = UC_LOW;
        return c;
    endfunction

    // Number of UTF-8 bytes minus one.
    function automatic t_byte_idx last_idx(input t_code_point cp);
        t_byte_idx n;
        if (cp < LIMIT_1B) n = LEN_1B;
        else if (cp < LIMIT_2B) n = LEN_2B;
        else if (cp < LIMIT_3B) n = LEN_3B;
        else n = LEN_4B;
        return n;
    endfunction

    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        return CONT_TAG | {2'b00, bits};
    endfunction

    // Byte number idx of the encoding of cp with given length code.
    function automatic logic [7:0] enc_byte(input t_code_point cp, input t_byte_idx len,
                                            input t_byte_idx idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (len)
            LEN_1B: b = {1'b0, cp[6:0]};
            LEN_2B: b = (idx == 2'd0) ? (LEAD_2B | {3'b000, cp[10:6]}) : cont_byte(cp[5:0]);
            LEN_3B: begin
                unique case (idx)
                    2'd0:    b = LEAD_3B | {4'b0000, cp[15:12]};
                    2'd1:    b = cont_byte(cp[11:6]);
                    default: b = cont_byte(cp[5:0]);
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0:    b = LEAD_4B | {5'b00000, cp[20:18]};
                    2'd1:    b = cont_byte(cp[17:12]);
                    2'd2:    b = cont_byte(cp[11:6]);
                    default: b = cont_byte(cp[5:0]);
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/u16u8_stream_if.sv =====
// Valid/ready channel interfaces for code units in and UTF-8 bytes out.
interface u16u8_unit_if;
    logic                valid;
    logic                ready;
    u16u8_pkg::t_code_unit code_unit;
    logic                start_of_string;

    modport source (output valid, code_unit, start_of_string, input ready);
    modport sink   (input valid, code_unit, start_of_string, output ready);
endinterface

interface u16u8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;

    modport source (output valid, out_byte, last_of_item, input ready);
    modport sink   (input valid, out_byte, last_of_item, output ready);
endinterface

// ===== hdl/u16u8_front.sv =====
// Front end: takes code units, pairs surrogates, pushes finished code points.
module u16u8_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    u16u8_unit_if.sink              i_unit,
    input  logic                    i_q_ready,
    output logic                    o_push,
    output u16u8_pkg::t_code_point  o_cp
);

    u16u8_pkg::t_code_point r_pending, n_pending;
    u16u8_pkg::t_code_point base;
    u16u8_pkg::t_unit_class cls;
    logic                   accept;

    assign i_unit.ready = i_q_ready;
    assign accept       = i_unit.valid && i_q_ready;
    assign cls          = u16u8_pkg::classify(i_unit.code_unit);
    assign base         = i_unit.start_of_string ? '0 : r_pending;

    always_comb begin
        n_pending = r_pending;
        o_push    = 1'b0;
        o_cp      = u16u8_pkg::CP_W'(i_unit.code_unit);
        unique case (cls)
            u16u8_pkg::UC_HIGH: begin
                n_pending = (u16u8_pkg::CP_W'(i_unit.code_unit[9:0]) << 10)
                          + u16u8_pkg::PLANE_BASE;
            end
            u16u8_pkg::UC_LOW: begin
                o_cp      = base | u16u8_pkg::CP_W'(i_unit.code_unit[9:0]);
                o_push    = accept;
                n_pending = '0;
            end
            default: begin
                o_push    = accept;
                n_pending = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (accept) begin
            r_pending <= n_pending;
        end
    end

endmodule

// ===== hdl/u16u8_queue.sv =====
// Small FIFO of code points between front and back end.
module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  u16u8_pkg::t_code_point  i_data,
    output logic                    o_ready,
    output logic                    o_valid,
    output u16u8_pkg::t_code_point  o_data,
    input  logic                    i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    u16u8_pkg::t_code_point mem [DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    logic                   do_push, do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= bump(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= bump(r_rd_ptr);
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

// ===== hdl/u16u8_back.sv =====
// Back end: encodes queued code points into UTF-8, one byte per cycle while the output is not stalled.
module u16u8_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  u16u8_pkg::t_code_point  i_q_data,
    output logic                    o_q_pop,
    u16u8_byte_if.source            o_byte
);

    logic                   r_busy;
    u16u8_pkg::t_code_point r_cp;
    u16u8_pkg::t_byte_idx   r_idx;
    logic                   r_o_valid;
    logic [7:0]             r_o_byte;
    logic                   r_o_last;

    u16u8_pkg::t_code_point src_cp;
    u16u8_pkg::t_byte_idx   src_idx, src_len;
    logic                   have, slot_free, fire, is_last;

    // Continue the code point in hand, else start on the queue head.
    assign src_cp    = r_busy ? r_cp : i_q_data;
    assign src_idx   = r_busy ? r_idx : '0;
    assign src_len   = u16u8_pkg::last_idx(src_cp);
    assign have      = r_busy || i_q_valid;
    assign slot_free = !r_o_valid || o_byte.ready;
    assign fire      = have && slot_free;
    assign is_last   = (src_idx == src_len);
    assign o_q_pop   = fire && !r_busy;

    assign o_byte.valid        = r_o_valid;
    assign o_byte.out_byte     = r_o_byte;
    assign o_byte.last_of_item = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (fire) begin
            r_o_valid <= 1'b1;
            r_busy    <= !is_last;
        end else if (o_byte.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_byte <= u16u8_pkg::enc_byte(src_cp, src_len, src_idx);
            r_o_last <= is_last;
            r_cp     <= src_cp;
            r_idx    <= src_idx + 1'b1;
        end
    end

endmodule

// ===== hdl/utf16_to_utf8_transcoder.sv =====
// Top level: UTF-16 code units in, UTF-8 bytes out with the last byte of each code point marked.
// An accepted unit's code point is written to the queue, then encoded into the output register.
// Output runs at one byte per cycle while o_byte.ready holds; a code point yields 1 to 4 bytes
//   from the single output byte register; a high surrogate yields no byte.
// The code-point queue (QUEUE_DEPTH entries) lets input run on while bytes drain.
// Reset (i_rst_n low, synchronous) clears the pending surrogate, the queue and the output.
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u16u8_unit_if.sink   i_unit,
    u16u8_byte_if.source o_byte
);

    // Front end -> queue
    logic                   push;
    u16u8_pkg::t_code_point push_cp;
    logic                   q_ready;

    // Queue -> back end
    logic                   q_valid;
    u16u8_pkg::t_code_point q_data;
    logic                   q_pop;

    // Front end: surrogate pairing. High surrogates only update the
    // pending value and never enter the queue.
    u16u8_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_unit    (i_unit),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cp      (push_cp)
    );

    // Decoupling queue of complete code points.
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cp),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    // Back end: byte sequencer with registered output.
    u16u8_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_byte    (o_byte)
    );

endmodule

// ===== hdl/u16u8_checker.sv =====
// Port-level checker for the transcoder, bound to the top level.
module u16u8_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_byte_valid,
    input logic       i_byte_ready,
    input logic [7:0] i_out_byte,
    input logic       i_last_of_item
);

    // A stalled byte stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte_valid && !i_byte_ready |=> i_byte_valid && $stable(i_out_byte)
            && $stable(i_last_of_item))
        else $error("output request dropped or changed while stalled");

    // Nothing is offered right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_byte_valid)
        else $error("output valid right after reset");

    // Bytes before the last one are lead or continuation bytes.
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte_valid && !i_last_of_item |-> i_out_byte[7])
        else $error("ASCII byte not marked last");

    // The last byte is never a lead byte.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte_valid && i_last_of_item |-> i_out_byte[7:6] != 2'b11)
        else $error("lead byte marked last");

    // A non-last continuation byte is never offered right after an ASCII byte completed.
    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_byte_valid && i_byte_ready && i_last_of_item |=> !(i_byte_valid
            && i_out_byte[7:6] == 2'b10 && !i_last_of_item
            && $past(i_out_byte[7]) == 1'b0))
        else $error("continuation byte follows a finished ASCII byte");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_byte_valid   (o_byte.valid),
    .i_byte_ready   (o_byte.ready),
    .i_out_byte     (o_byte.out_byte),
    .i_last_of_item (o_byte.last_of_item)
);
